[hw/rtl/rmft_pkg.sv]
`default_nettype none

package rmft_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_MAX    = 1000;
    localparam int COUNT_WIDTH = 32;

    localparam int ADDR_W     = $clog2(ADDR_MAX + 1);
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int USED_W     = $clog2(TABLE_DEPTH + 1);
    localparam int SW_ID_W    = 3;
    localparam int KIND_W     = 3;
    localparam int ACTION_W   = 3;
    localparam int PORT_W     = 2;
    localparam int ENT_ACT_W  = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = (ADDR_W > SW_ID_W) ? ADDR_W : SW_ID_W;

    localparam int S_TDATA_BITS = 4 * ADDR_W + SW_ID_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 1 + PORT_W + 2 * ADDR_W + IDX_W + COUNT_WIDTH + 1;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH_ID     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_RANGE_LOW = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_RANGE_HIGH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_PRESENT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_PRESENT = 3'd4;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TRAFFIC  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_FWD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_DROP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELAY_IN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK      = 3'd4;

    // result actions
    localparam logic [ACTION_W-1:0] ACTION_LOCAL = 3'd0;
    localparam logic [ACTION_W-1:0] ACTION_RELAY = 3'd1;
    localparam logic [ACTION_W-1:0] ACTION_QUERY = 3'd2;
    localparam logic [ACTION_W-1:0] ACTION_DROP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACTION_NONE  = 3'd4;

    // per-entry rule kinds
    localparam logic [ENT_ACT_W-1:0] ENT_DELIVER = 2'd0;
    localparam logic [ENT_ACT_W-1:0] ENT_FORWARD = 2'd1;
    localparam logic [ENT_ACT_W-1:0] ENT_DROP    = 2'd2;

    localparam logic [PORT_W-1:0] PORT_NONE  = 2'd0;
    localparam logic [PORT_W-1:0] PORT_LEFT  = 2'd1;
    localparam logic [PORT_W-1:0] PORT_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_DISC = 2'd0,
        MODE_CONN = 2'd1,
        MODE_WAIT = 2'd2
    } link_mode_t;

    typedef enum logic {
        CTRL_IDLE   = 1'b0,
        CTRL_SEARCH = 1'b1
    } ctrl_state_t;

    // lookup token walking down the row of cells
    typedef struct packed {
        logic                   active;
        logic                   bump0;
        logic                   hit;
        logic [ADDR_W-1:0]      dest;
        logic [IDX_W-1:0]       idx;
        logic [ENT_ACT_W-1:0]   act;
        logic [PORT_W-1:0]      port;
        logic [COUNT_WIDTH-1:0] count;
    } rmft_tok_t;

    // rule append broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [ADDR_W-1:0]    lo;
        logic [ADDR_W-1:0]    hi;
        logic [ENT_ACT_W-1:0] act;
        logic [PORT_W-1:0]    port;
    } rmft_wr_t;

    function automatic logic [PORT_W-1:0] port_if_present(
        input logic [PORT_W-1:0] port,
        input logic              left,
        input logic              right
    );
        logic [PORT_W-1:0] res;
        res = PORT_NONE;
        if (port == PORT_LEFT && left) begin
            res = PORT_LEFT;
        end else if (port == PORT_RIGHT && right) begin
            res = PORT_RIGHT;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rmft_cell.sv]
`default_nettype none

module rmft_cell
    import rmft_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [IDX_W-1:0]  cell_idx,
    input  wire logic [USED_W-1:0] used,
    input  wire logic [ADDR_W-1:0] own_lo,
    input  wire logic [ADDR_W-1:0] own_hi,
    input  wire rmft_wr_t          wr,
    input  wire rmft_tok_t         tok_in,
    output rmft_tok_t              tok_out
);

    logic [ADDR_W-1:0]      lo_reg;
    logic [ADDR_W-1:0]      hi_reg;
    logic [ENT_ACT_W-1:0]   act_reg;
    logic [PORT_W-1:0]      port_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    rmft_tok_t              tok_reg;
    rmft_tok_t              tok_next;

    logic                   is_root;
    logic                   in_use;
    logic [ADDR_W-1:0]      eff_lo;
    logic [ADDR_W-1:0]      eff_hi;
    logic                   match;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   wr_here;

    // entry zero takes its range live from configuration
    assign is_root   = (cell_idx == '0);
    assign in_use    = (USED_W'(cell_idx) < used);
    assign eff_lo    = is_root ? own_lo : lo_reg;
    assign eff_hi    = is_root ? own_hi : hi_reg;
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign wr_here   = wr.en && (wr.idx == cell_idx);

    always_comb begin
        match = 1'b0;
        if (tok_in.active && !tok_in.hit) begin
            if (tok_in.bump0) begin
                match = is_root;
            end else begin
                match = in_use && (eff_lo <= tok_in.dest) && (tok_in.dest <= eff_hi);
            end
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (match) begin
            tok_next.hit   = 1'b1;
            tok_next.idx   = cell_idx;
            tok_next.act   = is_root ? ENT_DELIVER : act_reg;
            tok_next.port  = port_reg;
            tok_next.count = count_inc;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (wr_here) begin
            count_next = COUNT_WIDTH'(1);
        end else if (match) begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_here) begin
            lo_reg   <= wr.lo;
            hi_reg   <= wr.hi;
            act_reg  <= wr.act;
            port_reg <= wr.port;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            tok_reg   <= '0;
        end else begin
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[hw/rtl/range_match_flow_table_core.sv]
// a traffic packet taken while connected, or a relay-in, walks the lookup row, each cell
// registering its token, and its result is then registered at the output; adds, acks,
// refused packets and other kinds go straight to the output register. no new item is
// taken during a search; other items go one per cycle while the result side keeps up.
// reset (aresetn low, synchronous): link disconnected, table holds entry zero only with
// its counter cleared, configuration back to its defaults, no result pending.
`default_nettype none

module range_match_flow_table_core
    import rmft_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // src_ip, dest_ip, rule_low, rule_high, rule_owner, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // accepted, out_port, out_src, out_dest, entry_index, entry_count, table_full, zero pad
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // action
    output logic [ACTION_W-1:0]        m_axis_tuser
);

    logic [SW_ID_W-1:0]     switch_id_reg;
    logic [ADDR_W-1:0]      own_lo_reg;
    logic [ADDR_W-1:0]      own_hi_reg;
    logic                   left_reg;
    logic                   right_reg;
    link_mode_t             mode_reg;
    link_mode_t             mode_next;
    logic [USED_W-1:0]      used_reg;
    logic [USED_W-1:0]      used_next;
    ctrl_state_t            state_reg;
    ctrl_state_t            state_next;
    logic [ADDR_W-1:0]      src_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_TDATA_W-1:0]   m_data_next;
    logic [ACTION_W-1:0]    m_user_reg;
    logic [ACTION_W-1:0]    m_user_next;

    logic [KIND_W-1:0]      in_kind;
    logic [ADDR_W-1:0]      in_src;
    logic [ADDR_W-1:0]      in_dest;
    logic [ADDR_W-1:0]      in_rlo;
    logic [ADDR_W-1:0]      in_rhi;
    logic [SW_ID_W-1:0]     in_owner;

    logic                   s_take;
    logic                   launch;
    logic                   is_add;
    logic                   full;
    logic [PORT_W-1:0]      add_port;
    rmft_wr_t               wr;
    rmft_tok_t              chain_tok [TABLE_DEPTH+1];
    rmft_tok_t              tail;

    // result fields
    logic                   r_accepted;
    logic [ACTION_W-1:0]    r_action;
    logic [PORT_W-1:0]      r_port;
    logic [ADDR_W-1:0]      r_src;
    logic [ADDR_W-1:0]      r_dest;
    logic [IDX_W-1:0]       r_idx;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_full;

    assign in_kind  = s_axis_tuser;
    assign in_src   = s_axis_tdata[ADDR_W-1:0];
    assign in_dest  = s_axis_tdata[2*ADDR_W-1:ADDR_W];
    assign in_rlo   = s_axis_tdata[3*ADDR_W-1:2*ADDR_W];
    assign in_rhi   = s_axis_tdata[4*ADDR_W-1:3*ADDR_W];
    assign in_owner = s_axis_tdata[4*ADDR_W +: SW_ID_W];

    assign s_take = s_axis_tvalid && s_axis_tready;
    assign launch = ((in_kind == KIND_TRAFFIC) && (mode_reg == MODE_CONN))
                    || (in_kind == KIND_RELAY_IN);
    assign is_add = (in_kind == KIND_ADD_FWD) || (in_kind == KIND_ADD_DROP);
    assign full   = (used_reg >= USED_W'(TABLE_DEPTH));
    assign add_port = (in_owner == switch_id_reg) ? PORT_RIGHT : PORT_LEFT;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_id_reg <= SW_ID_W'(1);
            own_lo_reg    <= '0;
            own_hi_reg    <= ADDR_W'(ADDR_MAX);
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SWITCH_ID:      switch_id_reg <= cfg_wdata[SW_ID_W-1:0];
                CFG_OWN_RANGE_LOW:  own_lo_reg    <= cfg_wdata[ADDR_W-1:0];
                CFG_OWN_RANGE_HIGH: own_hi_reg    <= cfg_wdata[ADDR_W-1:0];
                CFG_LEFT_PRESENT:   left_reg      <= cfg_wdata[0];
                CFG_RIGHT_PRESENT:  right_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // rule append goes straight into the cell at the fill count
    always_comb begin
        wr.en   = s_take && is_add && !full;
        wr.idx  = used_reg[IDX_W-1:0];
        wr.lo   = in_rlo;
        wr.hi   = (in_kind == KIND_ADD_FWD) ? in_rhi : in_rlo;
        wr.act  = (in_kind == KIND_ADD_FWD) ? ENT_FORWARD : ENT_DROP;
        wr.port = (in_kind == KIND_ADD_FWD) ? add_port : PORT_NONE;
    end

    always_comb begin
        chain_tok[0]        = '0;
        chain_tok[0].active = s_take && launch;
        chain_tok[0].bump0  = (in_kind == KIND_RELAY_IN);
        chain_tok[0].dest   = in_dest;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        rmft_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .used     (used_reg),
            .own_lo   (own_lo_reg),
            .own_hi   (own_hi_reg),
            .wr       (wr),
            .tok_in   (chain_tok[i]),
            .tok_out  (chain_tok[i+1])
        );
    end

    assign tail = chain_tok[TABLE_DEPTH];

    // control state: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE:   if (s_take && launch) state_next = CTRL_SEARCH;
            CTRL_SEARCH: if (tail.active) state_next = CTRL_IDLE;
            default:     state_next = CTRL_IDLE;
        endcase
    end

    // control state: outputs
    always_comb begin
        case (state_reg)
            CTRL_IDLE: s_axis_tready = !m_valid_reg || m_axis_tready;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        used_next = used_reg;
        if (wr.en) begin
            used_next = used_reg + 1'b1;
        end
        if (s_take && (is_add || in_kind == KIND_ACK)) begin
            mode_next = MODE_CONN;
        end else if (tail.active && !tail.bump0 && !tail.hit) begin
            mode_next = MODE_WAIT;
        end
    end

    // result of the item now finishing, from the token tail or the direct path
    always_comb begin
        r_accepted = 1'b1;
        r_action   = ACTION_NONE;
        r_port     = PORT_NONE;
        r_src      = '0;
        r_dest     = '0;
        r_idx      = '0;
        r_count    = '0;
        r_full     = 1'b0;
        if (tail.active) begin
            if (tail.bump0) begin
                r_idx   = tail.idx;
                r_count = tail.count;
            end else if (tail.hit) begin
                r_idx   = tail.idx;
                r_count = tail.count;
                case (tail.act)
                    ENT_FORWARD: begin
                        r_action = ACTION_RELAY;
                        r_port   = port_if_present(tail.port, left_reg, right_reg);
                        r_src    = src_reg;
                        r_dest   = tail.dest;
                    end
                    ENT_DROP: r_action = ACTION_DROP;
                    default:  r_action = ACTION_LOCAL;
                endcase
            end else begin
                r_action = ACTION_QUERY;
                r_src    = src_reg;
                r_dest   = tail.dest;
            end
        end else begin
            case (in_kind)
                KIND_TRAFFIC: r_accepted = 1'b0;
                KIND_ADD_FWD: begin
                    r_action = ACTION_RELAY;
                    r_port   = port_if_present(add_port, left_reg, right_reg);
                    r_src    = in_src;
                    r_dest   = in_dest;
                end
                KIND_ADD_DROP: r_action = ACTION_DROP;
                default: ;
            endcase
            if (is_add) begin
                if (full) begin
                    r_full = 1'b1;
                end else begin
                    r_idx   = used_reg[IDX_W-1:0];
                    r_count = COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if ((s_take && !launch) || tail.active) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_W'({r_full, r_count, r_idx, r_dest, r_src,
                                       r_port, r_accepted});
            m_user_next  = r_action;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_DISC;
            used_reg    <= USED_W'(1);
            state_reg   <= CTRL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            used_reg    <= used_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        if (s_take) begin
            src_reg <= in_src;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmft_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  rule_lo;
        logic [ADDR_W-1:0]  rule_hi;
        logic [SW_ID_W-1:0] owner;
    } pkt_item_t;

    typedef struct packed {
        logic                   accepted;
        logic [ACTION_W-1:0]    action;
        logic [PORT_W-1:0]      out_port;
        logic [ADDR_W-1:0]      out_src;
        logic [ADDR_W-1:0]      out_dest;
        logic [IDX_W-1:0]       entry_index;
        logic [COUNT_WIDTH-1:0] entry_count;
        logic                   table_full;
    } verdict_t;

    typedef struct packed {
        pkt_item_t item;
        logic      typed;
        verdict_t  want;
    } dir_row_t;

    // kinds outside the defined set, answered with a quiet result and otherwise ignored by the block
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam verdict_t REFUSED = '{1'b0, ACTION_NONE, PORT_NONE, '0, '0, '0, '0, 1'b0};
    localparam verdict_t QUIET   = '{1'b1, ACTION_NONE, PORT_NONE, '0, '0, '0, '0, 1'b0};
    localparam verdict_t UNTYPED = '0;

    localparam logic [SW_ID_W-1:0] DIR_SWITCH_ID = 3'd3;
    localparam int N_DIRECTED      = 24;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [ACTION_W-1:0]   m_axis_tuser;

    range_match_flow_table_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // shadow of the flow table and its configuration
    logic [ADDR_W-1:0]      tbl_lo    [TABLE_DEPTH];
    logic [ADDR_W-1:0]      tbl_hi    [TABLE_DEPTH];
    logic [ENT_ACT_W-1:0]   tbl_act   [TABLE_DEPTH];
    logic [PORT_W-1:0]      tbl_port  [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] tbl_count [TABLE_DEPTH];
    int                     tbl_used  = 1;
    link_mode_t             mode      = MODE_DISC;
    logic [SW_ID_W-1:0]     my_id     = 3'd1;
    logic [ADDR_W-1:0]      own_lo    = '0;
    logic [ADDR_W-1:0]      own_hi    = 10'd1000;
    logic                   left_up   = 1'b0;
    logic                   right_up  = 1'b0;
    logic [ADDR_W-1:0]      pend_src  = '0;
    logic [ADDR_W-1:0]      pend_dest = '0;

    verdict_t verdicts_due [$];
    int       mismatches   = 0;
    logic     busy         = 1'b0;
    logic     hold_request = 1'b0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        // traffic before the link is up
        '{'{KIND_TRAFFIC, 10'd5, 10'd150, 10'd0, 10'd0, 3'd1}, 1'b1, REFUSED},
        '{'{KIND_SPARE_LO, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 3'd7}, 1'b1, QUIET},
        '{'{KIND_SPARE_HI, 10'd0, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b1, QUIET},
        '{'{KIND_ACK, 10'd0, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b1, QUIET},
        '{'{KIND_TRAFFIC, 10'd0, 10'd100, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd1000, 10'd200, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_RELAY_IN, 10'd0, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd1000, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        // refused while waiting for the rule
        '{'{KIND_TRAFFIC, 10'd3, 10'd150, 10'd0, 10'd0, 3'd1}, 1'b1, REFUSED},
        '{'{KIND_ADD_FWD, 10'd1000, 10'd0, 10'd0, 10'd50, DIR_SWITCH_ID}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd7, 10'd50, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd1, 10'd999, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_ADD_DROP, 10'd1, 10'd999, 10'd999, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd2, 10'd999, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd4, 10'd1000, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_ADD_FWD, 10'd4, 10'd1000, 10'd1000, 10'd1000, 3'd7}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd511, 10'd1000, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd9, 10'd500, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_ACK, 10'd0, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b1, QUIET},
        // empty range, stored but never hit
        '{'{KIND_ADD_FWD, 10'd9, 10'd500, 10'd600, 10'd400, DIR_SWITCH_ID}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd9, 10'd500, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_RELAY_IN, 10'd0, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED},
        '{'{KIND_ADD_DROP, 10'd9, 10'd500, 10'd0, 10'd1000, 3'd2}, 1'b0, UNTYPED},
        '{'{KIND_TRAFFIC, 10'd1000, 10'd0, 10'd0, 10'd0, 3'd1}, 1'b0, UNTYPED}
    };

    function automatic logic [PORT_W-1:0] reachable(input logic [PORT_W-1:0] p);
        if (p == PORT_LEFT && left_up) return PORT_LEFT;
        if (p == PORT_RIGHT && right_up) return PORT_RIGHT;
        return PORT_NONE;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump_count(input int idx);
        if (tbl_count[idx] != '1) tbl_count[idx] = tbl_count[idx] + 1'b1;
        return tbl_count[idx];
    endfunction

    function automatic logic store_rule(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                                        input logic [ENT_ACT_W-1:0] act,
                                        input logic [PORT_W-1:0] port,
                                        input logic [COUNT_WIDTH-1:0] count);
        if (tbl_used >= TABLE_DEPTH) return 1'b0;
        tbl_lo[tbl_used]    = lo;
        tbl_hi[tbl_used]    = hi;
        tbl_act[tbl_used]   = act;
        tbl_port[tbl_used]  = port;
        tbl_count[tbl_used] = count;
        tbl_used++;
        return 1'b1;
    endfunction

    task automatic classify_item(input pkt_item_t it, output verdict_t v);
        int                i;
        logic              hit;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [PORT_W-1:0] port;
        v = QUIET;
        case (it.kind)
            KIND_TRAFFIC: begin
                if (mode != MODE_CONN) begin
                    v = REFUSED;
                end else begin
                    hit = 1'b0;
                    i = 0;
                    // first entry whose inclusive range holds the destination wins
                    while (i < tbl_used && !hit) begin
                        lo = (i == 0) ? own_lo : tbl_lo[i];
                        hi = (i == 0) ? own_hi : tbl_hi[i];
                        if (lo <= it.dest && it.dest <= hi) hit = 1'b1;
                        else i++;
                    end
                    if (hit) begin
                        v.entry_index = i[IDX_W-1:0];
                        v.entry_count = bump_count(i);
                        if (i != 0 && tbl_act[i] == ENT_FORWARD) begin
                            v.action   = ACTION_RELAY;
                            v.out_port = reachable(tbl_port[i]);
                            v.out_src  = it.src;
                            v.out_dest = it.dest;
                        end else if (i != 0 && tbl_act[i] == ENT_DROP) begin
                            v.action = ACTION_DROP;
                        end else begin
                            v.action = ACTION_LOCAL;
                        end
                    end else begin
                        v.action   = ACTION_QUERY;
                        v.out_src  = it.src;
                        v.out_dest = it.dest;
                        pend_src   = it.src;
                        pend_dest  = it.dest;
                        mode       = MODE_WAIT;
                    end
                end
            end
            KIND_ADD_FWD: begin
                port       = (it.owner == my_id) ? PORT_RIGHT : PORT_LEFT;
                v.action   = ACTION_RELAY;
                v.out_port = reachable(port);
                v.out_src  = it.src;
                v.out_dest = it.dest;
                if (store_rule(it.rule_lo, it.rule_hi, ENT_FORWARD, port, '0)) begin
                    v.entry_index = IDX_W'(tbl_used - 1);
                    v.entry_count = bump_count(tbl_used - 1);
                end else begin
                    v.table_full = 1'b1;
                end
                mode = MODE_CONN;
            end
            KIND_ADD_DROP: begin
                v.action = ACTION_DROP;
                if (store_rule(it.rule_lo, it.rule_lo, ENT_DROP, PORT_NONE,
                               COUNT_WIDTH'(1))) begin
                    v.entry_index = IDX_W'(tbl_used - 1);
                    v.entry_count = tbl_count[tbl_used - 1];
                end else begin
                    v.table_full = 1'b1;
                end
                mode = MODE_CONN;
            end
            KIND_RELAY_IN: begin
                v.entry_count = bump_count(0);
            end
            KIND_ACK: begin
                mode = MODE_CONN;
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [ADDR_W-1:0] clamp_addr(input int x);
        if (x < 0) return '0;
        if (x > ADDR_MAX) return ADDR_W'(ADDR_MAX);
        return ADDR_W'(x);
    endfunction

    function automatic logic [ADDR_W-1:0] any_addr();
        return ADDR_W'($urandom_range(ADDR_MAX, 0));
    endfunction

    // half the destinations sit on or just outside the edge of a stored range
    function automatic logic [ADDR_W-1:0] aim_dest();
        int e;
        int lo;
        int hi;
        int pick;
        if ($urandom_range(1, 0) == 0) return any_addr();
        e  = $urandom_range(tbl_used - 1, 0);
        lo = (e == 0) ? own_lo : tbl_lo[e];
        hi = (e == 0) ? own_hi : tbl_hi[e];
        case ($urandom_range(3, 0))
            0:       pick = lo;
            1:       pick = hi;
            2:       pick = lo - 1;
            default: pick = hi + 1;
        endcase
        return clamp_addr(pick);
    endfunction

    function automatic int idle_len();
        int r;
        if (busy) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic make_item(output pkt_item_t it);
        int r;
        int lo;
        int hi;
        int d;
        r        = $urandom_range(99, 0);
        it.src   = any_addr();
        it.dest  = aim_dest();
        it.owner = $urandom_range(1, 0) ? my_id
                                        : SW_ID_W'($urandom_range((1 << SW_ID_W) - 1, 1));
        lo = $urandom_range(ADDR_MAX, 0);
        case ($urandom_range(9, 0))
            0:       hi = $urandom_range(ADDR_MAX, 0);
            1:       begin lo = 0; hi = ADDR_MAX; end
            default: hi = lo + int'($urandom_range(80, 0));
        endcase
        if (mode == MODE_CONN) begin
            if (r < 76)      it.kind = KIND_TRAFFIC;
            else if (r < 86) it.kind = KIND_RELAY_IN;
            else if (r < 87) it.kind = KIND_ADD_FWD;
            else if (r < 88) it.kind = KIND_ADD_DROP;
            else if (r < 94) it.kind = KIND_ACK;
            else             it.kind = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        end else begin
            // mostly the controller answering the pending query
            d = int'(pend_dest);
            if (r < 20) begin
                it.kind = (r < 15) ? KIND_ADD_FWD : KIND_ADD_DROP;
                it.src  = pend_src;
                it.dest = pend_dest;
                if (r < 12) begin
                    lo = d - int'($urandom_range(40, 0));
                    hi = d + int'($urandom_range(40, 0));
                end else if (r >= 15) begin
                    lo = d;
                end
            end else if (r < 85) begin
                it.kind = KIND_ACK;
            end else if (r < 93) begin
                it.kind = KIND_TRAFFIC;
            end else if (r < 97) begin
                it.kind = KIND_RELAY_IN;
            end else begin
                it.kind = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
            end
        end
        it.rule_lo = clamp_addr(lo);
        it.rule_hi = clamp_addr(hi);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
    endtask

    task automatic apply_config(input logic [SW_ID_W-1:0] sw, input logic [ADDR_W-1:0] lo,
                                input logic [ADDR_W-1:0] hi, input logic l, input logic r);
        cfg_write(CFG_SWITCH_ID, CFG_DATA_W'(sw));
        cfg_write(CFG_OWN_RANGE_LOW, CFG_DATA_W'(lo));
        cfg_write(CFG_OWN_RANGE_HIGH, CFG_DATA_W'(hi));
        cfg_write(CFG_LEFT_PRESENT, CFG_DATA_W'(l));
        cfg_write(CFG_RIGHT_PRESENT, CFG_DATA_W'(r));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        my_id    = sw;
        own_lo   = lo;
        own_hi   = hi;
        left_up  = l;
        right_up = r;
    endtask

    task automatic offer_item(input pkt_item_t it, input logic typed, input verdict_t want);
        verdict_t v;
        int       gap;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({it.owner, it.rule_hi, it.rule_lo, it.dest, it.src});
        s_axis_tuser  <= it.kind;
        do @(posedge aclk); while (!s_axis_tready);
        classify_item(it, v);
        verdicts_due = {verdicts_due, (typed ? want : v)};
        gap = idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic quiesce();
        if (s_axis_tvalid) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        pkt_item_t         it;
        int                k;
        int                ph;
        int                n;
        logic [ADDR_W-1:0] lo;
        tbl_count[0] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apply_config(DIR_SWITCH_ID, 10'd100, 10'd200, 1'b1, 1'b0);
        for (k = 0; k < N_DIRECTED; k++) begin
            offer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        end
        quiesce();

        for (ph = 0; ph < N_PHASES; ph++) begin
            lo = any_addr();
            case (ph)
                0: apply_config(3'd1, '0, ADDR_W'(ADDR_MAX), 1'b1, 1'b1);
                1: apply_config(3'd7, ADDR_W'(ADDR_MAX), '0, 1'b0, 1'b0);
                2: apply_config(SW_ID_W'($urandom_range(7, 1)), ADDR_W'(ADDR_MAX),
                                ADDR_W'(ADDR_MAX), 1'($urandom), 1'($urandom));
                default: apply_config(SW_ID_W'($urandom_range(7, 1)), lo,
                                      clamp_addr(lo + int'($urandom_range(300, 0))),
                                      1'($urandom), 1'($urandom));
            endcase
            busy = (ph == 3 || ph == 4);
            // long hold-off on the result side while items keep coming
            if (ph == 4) hold_request = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                make_item(it);
                offer_item(it, 1'b0, UNTYPED);
            end
            quiesce();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    task automatic check_field(input string fname, input logic [COUNT_WIDTH-1:0] want,
                               input logic [COUNT_WIDTH-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : verdict_check
        verdict_t got;
        verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            // accepted, out_port, out_src, out_dest, entry_index, entry_count, table_full
            got.accepted    = m_axis_tdata[0];
            got.out_port    = m_axis_tdata[2:1];
            got.out_src     = m_axis_tdata[12:3];
            got.out_dest    = m_axis_tdata[22:13];
            got.entry_index = m_axis_tdata[26:23];
            got.entry_count = m_axis_tdata[58:27];
            got.table_full  = m_axis_tdata[59];
            got.action      = m_axis_tuser;
            if (verdicts_due.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("accepted", COUNT_WIDTH'(want.accepted),
                            COUNT_WIDTH'(got.accepted));
                check_field("action", COUNT_WIDTH'(want.action), COUNT_WIDTH'(got.action));
                check_field("out_port", COUNT_WIDTH'(want.out_port),
                            COUNT_WIDTH'(got.out_port));
                check_field("out_src", COUNT_WIDTH'(want.out_src), COUNT_WIDTH'(got.out_src));
                check_field("out_dest", COUNT_WIDTH'(want.out_dest),
                            COUNT_WIDTH'(got.out_dest));
                check_field("entry_index", COUNT_WIDTH'(want.entry_index),
                            COUNT_WIDTH'(got.entry_index));
                check_field("entry_count", want.entry_count, got.entry_count);
                check_field("table_full", COUNT_WIDTH'(want.table_full),
                            COUNT_WIDTH'(got.table_full));
            end
        end
    end

    initial begin : watchdog
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/rmft_pkg.sv
hw/rtl/rmft_cell.sv
hw/rtl/range_match_flow_table_core.sv
tb/sv/tb_top.sv
